FILE: sv/plc_pkg.sv
// Shared types and constants for the perspective line clipper.
// No dependencies; imported by every module of the block.
package plc_pkg;

    localparam int CW     = 32;  // coordinate width
    localparam int DW     = 33;  // coordinate difference width
    localparam int NW     = 35;  // plane numerator / denominator width
    localparam int MW     = 34;  // magnitude of numerator / denominator
    localparam int RW     = MW + 1;  // divider partial remainder
    localparam int NZW    = 17;  // near plane register width
    localparam int NPLANE = 6;

    localparam logic signed [NZW-1:0] NEAR_Z_RESET = -17'sd6554;

    // plane order used through the pipe
    localparam int PL_XPOS = 0;  // x = -z side
    localparam int PL_XNEG = 1;
    localparam int PL_YPOS = 2;
    localparam int PL_YNEG = 3;
    localparam int PL_NEAR = 4;
    localparam int PL_FAR  = 5;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] delta_t;
    typedef logic signed [NW-1:0] nd_t;
    typedef logic [MW-1:0]        mag_t;

    typedef struct packed {
        logic den_pos;
        logic den_neg;
        logic num_pos;
    } plane_flags_t;

    typedef struct packed {
        logic zero;  // numerator zero: t = 0
        logic neg;   // signs differ: t = -1
        logic ovf;   // quotient 2.0 or above: t held at 1.0 + 1 LSB
    } t_spec_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t z0;
        coord_t x1;
        coord_t y1;
        coord_t z1;
        delta_t dx;
        delta_t dy;
        delta_t dz;
    } seg_t;

endpackage

FILE: sv/plc_div.sv
// Pipelined restoring divider for one clip plane: t = floor(a * 2^F / b), held.
// One quotient bit per stage. Depends on plc_pkg.
module plc_div
    import plc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  mag_t                        a,
    input  mag_t                        b,
    input  logic                        zero_in,
    input  logic                        neg_in,
    input  plane_flags_t                flags_in,
    output logic signed [FRAC_BITS+2:0] t_out,
    output plane_flags_t                flags_out
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam logic [QW-1:0] T_SAT = QW'((1 << FRAC_BITS) + 1);

    logic [RW-1:0]  r_reg     [STEPS-1];
    mag_t           b_reg     [STEPS-1];
    logic [QW-1:0]  q_reg     [STEPS];
    t_spec_t        spec_reg  [STEPS];
    plane_flags_t   flags_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [RW-1:0] r_in;
        logic [QW-1:0] q_in;
        mag_t          b_in;
        t_spec_t       spec_in;
        plane_flags_t  fl_in;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in         = RW'(a);
            assign q_in         = '0;
            assign b_in         = b;
            assign spec_in.zero = zero_in;
            assign spec_in.neg  = neg_in;
            assign spec_in.ovf  = ({1'b0, a} >= {b, 1'b0});
            assign fl_in        = flags_in;
        end else begin : g_next
            assign r_in    = {r_reg[k-1][RW-2:0], 1'b0};
            assign q_in    = q_reg[k-1];
            assign b_in    = b_reg[k-1];
            assign spec_in = spec_reg[k-1];
            assign fl_in   = flags_reg[k-1];
        end

        assign ge = (r_in >= RW'(b_in));

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]     <= {q_in[QW-2:0], ge};
                spec_reg[k]  <= spec_in;
                flags_reg[k] <= fl_in;
            end
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k] <= ge ? (r_in - RW'(b_in)) : r_in;
                    b_reg[k] <= b_in;
                end
            end
        end
    end

    always_comb begin
        if (spec_reg[STEPS-1].zero) begin
            t_out = '0;
        end else if (spec_reg[STEPS-1].neg) begin
            t_out = '1;
        end else if (spec_reg[STEPS-1].ovf || (q_reg[STEPS-1] > T_SAT)) begin
            t_out = $signed({2'b00, T_SAT});
        end else begin
            t_out = $signed({2'b00, q_reg[STEPS-1]});
        end
    end

    assign flags_out = flags_reg[STEPS-1];

endmodule

FILE: sv/plc_clip.sv
// Liang-Barsky parameter update over the six planes, two planes per stage.
// Three register stages. Depends on plc_pkg.
module plc_clip
    import plc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [FRAC_BITS+2:0] t_in     [NPLANE],
    input  plane_flags_t                flags_in [NPLANE],
    output logic                        alive_out,
    output logic signed [FRAC_BITS+2:0] te_out,
    output logic signed [FRAC_BITS+2:0] tl_out
);

    localparam int TW     = FRAC_BITS + 3;
    localparam int NST    = 3;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

    logic signed [TW-1:0] te_reg    [NST];
    logic signed [TW-1:0] tl_reg    [NST];
    logic                 alive_reg [NST];
    logic signed [TW-1:0] t_reg     [NST-1][NPLANE];
    plane_flags_t         fl_reg    [NST-1][NPLANE];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic signed [TW-1:0] te_i, tl_i, te_n, tl_n;
        logic                 al_i, al_n;
        logic signed [TW-1:0] t_i  [NPLANE];
        plane_flags_t         fl_i [NPLANE];

        if (s == 0) begin : g_first
            assign te_i = '0;
            assign tl_i = T_ONE;
            assign al_i = 1'b1;
            assign t_i  = t_in;
            assign fl_i = flags_in;
        end else begin : g_next
            assign te_i = te_reg[s-1];
            assign tl_i = tl_reg[s-1];
            assign al_i = alive_reg[s-1];
            assign t_i  = t_reg[s-1];
            assign fl_i = fl_reg[s-1];
        end

        always_comb begin
            te_n = te_i;
            tl_n = tl_i;
            al_n = al_i;
            for (int p = 2 * s; p < 2 * s + 2; p++) begin
                if (al_n) begin
                    if (fl_i[p].den_pos) begin
                        if (t_i[p] > tl_n) begin
                            al_n = 1'b0;
                        end else if (t_i[p] < tl_n && t_i[p] > te_n) begin
                            te_n = t_i[p];
                        end
                    end else if (fl_i[p].den_neg) begin
                        if (t_i[p] < te_n) begin
                            al_n = 1'b0;
                        end else if (t_i[p] > te_n && t_i[p] < tl_n) begin
                            tl_n = t_i[p];
                        end
                    end else if (fl_i[p].num_pos) begin
                        al_n = 1'b0;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                te_reg[s]    <= te_n;
                tl_reg[s]    <= tl_n;
                alive_reg[s] <= al_n;
            end
        end

        if (s < NST - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    t_reg[s]  <= t_i;
                    fl_reg[s] <= fl_i;
                end
            end
        end
    end

    assign alive_out = alive_reg[NST-1];
    assign te_out    = te_reg[NST-1];
    assign tl_out    = tl_reg[NST-1];

endmodule

FILE: sv/plc_lerp.sv
// One clipped coordinate: base + round(t * d), saturated, or the original value.
// Two register stages (product, then round/add/saturate). Depends on plc_pkg.
module plc_lerp
    import plc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        use_in,
    input  coord_t                      base,
    input  coord_t                      orig,
    input  delta_t                      d,
    input  logic signed [FRAC_BITS+2:0] t,
    output coord_t                      out
);

    localparam int PW = FRAC_BITS + 2 + DW;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] T_HALF = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] C_MAX  = SW'(32'sh7fffffff);
    localparam logic signed [SW-1:0] C_MIN  = -(SW'(32'sh7fffffff)) - SW'(1);

    logic signed [PW-1:0] prod_reg;
    coord_t               base_reg;
    coord_t               orig_reg;
    logic                 use_reg;
    coord_t               out_reg;

    logic signed [FRAC_BITS+1:0] t_pos;
    logic signed [SW-1:0]        p_rnd, r_sh, sum;

    // t is never negative when used
    assign t_pos = t[FRAC_BITS+1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(t_pos) * PW'(d);
            base_reg <= base;
            orig_reg <= orig;
            use_reg  <= use_in;
        end
    end

    // arithmetic shift of (p + half) is floor, matching round-half-up
    assign p_rnd = SW'(prod_reg) + T_HALF;
    assign r_sh  = p_rnd >>> FRAC_BITS;
    assign sum   = SW'(base_reg) + r_sh;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!use_reg) begin
                out_reg <= orig_reg;
            end else if (sum > C_MAX) begin
                out_reg <= C_MAX[CW-1:0];
            end else if (sum < C_MIN) begin
                out_reg <= C_MIN[CW-1:0];
            end else begin
                out_reg <= sum[CW-1:0];
            end
        end
    end

    assign out = out_reg;

endmodule

FILE: sv/perspective_line_clip_3d.sv
// Perspective view volume line clipper, Liang-Barsky, signed fixed point.
// Throughput: one segment per cycle when not stalled; the FRAC_BITS + 1 stage divider per plane sets depth.
// All stages advance together when the output register is empty or taken.
// Reset (aresetn low, synchronous) clears valid bits and loads near_plane_z with -6554.
module perspective_line_clip_3d
    import plc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    // config: near_plane_z, signed
    input  logic           cfg_wen,
    input  logic [NZW-1:0] cfg_wdata,
    // request in
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [191:0]   s_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
    // result out
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [191:0]   m_tdata,   // clip_start_x, _y, _z, clip_end_x, _y, _z
    output logic [0:0]     m_tuser    // accepted
);

    localparam int TW       = FRAC_BITS + 3;
    localparam int SIDE_LEN = FRAC_BITS + 6;  // segment data needed up to lerp input
    localparam int PIPE_LEN = FRAC_BITS + 8;
    localparam logic signed [NW-1:0] T_ONE_ND = NW'(1) << FRAC_BITS;
    localparam logic signed [TW-1:0] T_ONE_T  = TW'(1) << FRAC_BITS;

    logic signed [NZW-1:0] near_z_reg;

    logic   en;
    logic   valid_reg [PIPE_LEN];
    seg_t   side_reg  [SIDE_LEN];
    seg_t   seg_in;

    // stage 1: plane numerators / denominators
    nd_t    num_next [NPLANE];
    nd_t    den_next [NPLANE];
    nd_t    num_reg  [NPLANE];
    nd_t    den_reg  [NPLANE];

    // stage 2: magnitudes and special cases
    mag_t         a_reg    [NPLANE];
    mag_t         b_reg    [NPLANE];
    logic         zero_reg [NPLANE];
    logic         neg_reg  [NPLANE];
    plane_flags_t flags_reg[NPLANE];

    logic signed [TW-1:0] t_div  [NPLANE];
    plane_flags_t         fl_div [NPLANE];

    logic                 alive;
    logic signed [TW-1:0] te, tl;
    logic                 use_s, use_e;
    logic                 acc_mul_reg, acc_out_reg;
    seg_t                 sg;
    coord_t               out_sx, out_sy, out_sz, out_ex, out_ey, out_ez;

    // whole pipe moves unless a result sits unclaimed at the output
    assign en       = !valid_reg[PIPE_LEN-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[PIPE_LEN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_z_reg <= NEAR_Z_RESET;
        end else if (cfg_wen) begin
            near_z_reg <= $signed(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LEN; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_LEN; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // unpack the request
    assign seg_in.x0 = $signed(s_tdata[31:0]);
    assign seg_in.y0 = $signed(s_tdata[63:32]);
    assign seg_in.z0 = $signed(s_tdata[95:64]);
    assign seg_in.x1 = $signed(s_tdata[127:96]);
    assign seg_in.y1 = $signed(s_tdata[159:128]);
    assign seg_in.z1 = $signed(s_tdata[191:160]);
    assign seg_in.dx = DW'(seg_in.x1) - DW'(seg_in.x0);
    assign seg_in.dy = DW'(seg_in.y1) - DW'(seg_in.y0);
    assign seg_in.dz = DW'(seg_in.z1) - DW'(seg_in.z0);

    // segment data rides alongside the arithmetic
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= seg_in;
            for (int i = 1; i < SIDE_LEN; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // plane equations, exact
    always_comb begin
        den_next[PL_XPOS] = NW'(seg_in.x0) - NW'(seg_in.x1) + NW'(seg_in.z0) - NW'(seg_in.z1);
        num_next[PL_XPOS] = NW'(seg_in.x0) + NW'(seg_in.z0);
        den_next[PL_XNEG] = NW'(seg_in.x1) - NW'(seg_in.x0) + NW'(seg_in.z0) - NW'(seg_in.z1);
        num_next[PL_XNEG] = NW'(seg_in.z0) - NW'(seg_in.x0);
        den_next[PL_YPOS] = NW'(seg_in.y1) - NW'(seg_in.y0) + NW'(seg_in.z0) - NW'(seg_in.z1);
        num_next[PL_YPOS] = NW'(seg_in.z0) - NW'(seg_in.y0);
        den_next[PL_YNEG] = NW'(seg_in.y0) - NW'(seg_in.y1) + NW'(seg_in.z0) - NW'(seg_in.z1);
        num_next[PL_YNEG] = NW'(seg_in.y0) + NW'(seg_in.z0);
        den_next[PL_NEAR] = NW'(seg_in.z0) - NW'(seg_in.z1);
        num_next[PL_NEAR] = NW'(seg_in.z0) - NW'(near_z_reg);
        den_next[PL_FAR]  = NW'(seg_in.z1) - NW'(seg_in.z0);
        num_next[PL_FAR]  = -NW'(seg_in.z0) - T_ONE_ND;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // magnitudes for the unsigned divider; sign cases resolved here
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < NPLANE; p++) begin
                a_reg[p]             <= (num_reg[p] < 0) ? MW'(-num_reg[p]) : MW'(num_reg[p]);
                b_reg[p]             <= (den_reg[p] < 0) ? MW'(-den_reg[p]) : MW'(den_reg[p]);
                zero_reg[p]          <= (num_reg[p] == '0);
                neg_reg[p]           <= ((num_reg[p] < 0) != (den_reg[p] < 0));
                flags_reg[p].den_pos <= (den_reg[p] > 0);
                flags_reg[p].den_neg <= (den_reg[p] < 0);
                flags_reg[p].num_pos <= (num_reg[p] > 0);
            end
        end
    end

    for (genvar p = 0; p < NPLANE; p++) begin : g_plane
        plc_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .aclk      (aclk),
            .en        (en),
            .a         (a_reg[p]),
            .b         (b_reg[p]),
            .zero_in   (zero_reg[p]),
            .neg_in    (neg_reg[p]),
            .flags_in  (flags_reg[p]),
            .t_out     (t_div[p]),
            .flags_out (fl_div[p])
        );
    end

    plc_clip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clip (
        .aclk      (aclk),
        .en        (en),
        .t_in      (t_div),
        .flags_in  (fl_div),
        .alive_out (alive),
        .te_out    (te),
        .tl_out    (tl)
    );

    // endpoints move only when their parameter moved off the segment end
    assign sg    = side_reg[SIDE_LEN-1];
    assign use_s = alive && (te > 0);
    assign use_e = alive && (tl < T_ONE_T);

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_mul_reg <= alive;
            acc_out_reg <= acc_mul_reg;
        end
    end

    plc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_sx (
        .aclk(aclk), .en(en), .use_in(use_s), .base(sg.x0), .orig(sg.x0),
        .d(sg.dx), .t(te), .out(out_sx)
    );
    plc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_sy (
        .aclk(aclk), .en(en), .use_in(use_s), .base(sg.y0), .orig(sg.y0),
        .d(sg.dy), .t(te), .out(out_sy)
    );
    plc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_sz (
        .aclk(aclk), .en(en), .use_in(use_s), .base(sg.z0), .orig(sg.z0),
        .d(sg.dz), .t(te), .out(out_sz)
    );
    plc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_ex (
        .aclk(aclk), .en(en), .use_in(use_e), .base(sg.x0), .orig(sg.x1),
        .d(sg.dx), .t(tl), .out(out_ex)
    );
    plc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_ey (
        .aclk(aclk), .en(en), .use_in(use_e), .base(sg.y0), .orig(sg.y1),
        .d(sg.dy), .t(tl), .out(out_ey)
    );
    plc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_ez (
        .aclk(aclk), .en(en), .use_in(use_e), .base(sg.z0), .orig(sg.z1),
        .d(sg.dz), .t(tl), .out(out_ez)
    );

    assign m_tdata = {out_ez, out_ey, out_ex, out_sz, out_sy, out_sx};
    assign m_tuser = acc_out_reg;

endmodule
